>>> rtl/modbus_rtu_slave_frame_handler_assert.svh
// Assertion macros used by the checker file mrtu_checker.sv.
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define MRTU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrtu assertion failed");

// Next-cycle implication, quiet while reset is high
`define MRTU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrtu assertion failed");

// Next-cycle implication that also holds across reset
`define MRTU_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mrtu reset assertion failed");

`endif

>>> rtl/mrtu_pkg.sv
package mrtu_pkg;

  // Frame layout
  localparam int FRAME_BYTES     = 8;
  localparam int CRC_BYTES       = 6;
  localparam int READ_RESP_BYTES = 7;
  localparam int READ_CRC_BYTES  = 5;

  // Modbus constants
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FN_READ         = 8'h03;
  localparam logic [7:0]  FN_WRITE        = 8'h06;
  localparam logic [7:0]  READ_BYTE_COUNT = 8'h02;
  localparam logic [15:0] UNKNOWN_VALUE   = 16'hFFFF;
  localparam logic [15:0] OPEN_VALUE      = 16'h0001;

  // Valve action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STATE_ADDRESS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_VOLTAGE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_VOLTAGE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ENCODER         = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_VALVE_COMMAND   = 3'd6;

  localparam logic [7:0]  DEVICE_ADDRESS_RST  = 8'd1;
  localparam logic [15:0] VALVE_STATE_RST     = 16'd0;
  localparam logic [15:0] BATTERY_VOLTAGE_RST = 16'd1;
  localparam logic [15:0] PANEL_VOLTAGE_RST   = 16'd2;
  localparam logic [15:0] CURRENT_RST         = 16'd3;
  localparam logic [15:0] ENCODER_RST         = 16'd4;
  localparam logic [15:0] VALVE_COMMAND_RST   = 16'd16;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] valve_state_address;
    logic [15:0] battery_voltage_address;
    logic [15:0] panel_voltage_address;
    logic [15:0] current_address;
    logic [15:0] encoder_address;
    logic [15:0] valve_command_address;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic rx_take;
    logic check;
    logic rcrc_step;
    logic push;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic do_read;
    logic do_echo;
    logic rcrc_last;
    logic send_last;
    logic out_free;
  } stat_t;

  // One byte of Modbus CRC-16, reflected
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/mrtu_if.sv
// Received byte channel
interface mrtu_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        rx_last;
  logic [15:0] valve_state;
  logic [15:0] battery_mv;
  logic [15:0] panel_mv;
  logic [15:0] current_ma;
  logic [15:0] encoder_low;

  modport source (output valid, rx_byte, rx_last, valve_state, battery_mv, panel_mv,
                  current_ma, encoder_low, input ready);
  modport sink (input valid, rx_byte, rx_last, valve_state, battery_mv, panel_mv,
                current_ma, encoder_low, output ready);
endinterface

// Response byte channel
interface mrtu_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [1:0] valve_action;

  modport source (output valid, tx_byte, tx_last, valve_action, input ready);
  modport sink (input valid, tx_byte, tx_last, valve_action, output ready);
endinterface

>>> rtl/modbus_rtu_slave_frame_handler.sv
// Channel  Dir  Handshake     Payload
// rx       in   valid/ready   rx_byte, rx_last, valve_state, battery_mv, panel_mv,
//                             current_ma, encoder_low
// tx       out  valid/ready   tx_byte, tx_last, valve_action
// cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
// Frame bytes are taken one per cycle while the controller is in its receive
// state. The last byte is followed by a check state; a read request then runs
// its first five response bytes through the response CRC, one byte per cycle,
// before the response goes out one byte per cycle while tx is ready.
// The output register holds a waiting byte while the next frame is received.
// Reset is synchronous; it returns count, CRC and the controller to idle.
module modbus_rtu_slave_frame_handler (
  input  logic                             clk,
  input  logic                             rst,
  mrtu_rx_if.sink                          rx,
  mrtu_tx_if.source                        tx,
  input  logic                             cfg_we,
  input  logic [mrtu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrtu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mrtu_pkg::cfg_t  cfg;
  mrtu_pkg::cmd_t  cmd;
  mrtu_pkg::stat_t stat;
  logic            rx_ready;

  assign rx.ready = rx_ready;

  mrtu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_last  (rx.rx_last),
    .rx_ready (rx_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrtu_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .rx_byte      (rx.rx_byte),
    .rx_last      (rx.rx_last),
    .valve_state  (rx.valve_state),
    .battery_mv   (rx.battery_mv),
    .panel_mv     (rx.panel_mv),
    .current_ma   (rx.current_ma),
    .encoder_low  (rx.encoder_low),
    .tx_ready     (tx.ready),
    .tx_valid     (tx.valid),
    .tx_byte      (tx.tx_byte),
    .tx_last      (tx.tx_last),
    .valve_action (tx.valve_action)
  );

endmodule

>>> rtl/mrtu_cfg.sv
module mrtu_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mrtu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mrtu_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mrtu_pkg::cfg_t                      cfg
);

  // Register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address          <= mrtu_pkg::DEVICE_ADDRESS_RST;
      cfg.valve_state_address     <= mrtu_pkg::VALVE_STATE_RST;
      cfg.battery_voltage_address <= mrtu_pkg::BATTERY_VOLTAGE_RST;
      cfg.panel_voltage_address   <= mrtu_pkg::PANEL_VOLTAGE_RST;
      cfg.current_address         <= mrtu_pkg::CURRENT_RST;
      cfg.encoder_address         <= mrtu_pkg::ENCODER_RST;
      cfg.valve_command_address   <= mrtu_pkg::VALVE_COMMAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mrtu_pkg::REG_DEVICE_ADDRESS:  cfg.device_address          <= cfg_data[7:0];
        mrtu_pkg::REG_STATE_ADDRESS:   cfg.valve_state_address     <= cfg_data;
        mrtu_pkg::REG_BATTERY_VOLTAGE: cfg.battery_voltage_address <= cfg_data;
        mrtu_pkg::REG_PANEL_VOLTAGE:   cfg.panel_voltage_address   <= cfg_data;
        mrtu_pkg::REG_CURRENT:         cfg.current_address         <= cfg_data;
        mrtu_pkg::REG_ENCODER:         cfg.encoder_address         <= cfg_data;
        mrtu_pkg::REG_VALVE_COMMAND:   cfg.valve_command_address   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/mrtu_ctrl.sv
module mrtu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            rx_valid,
  input  logic            rx_last,
  output logic            rx_ready,
  input  mrtu_pkg::stat_t stat,
  output mrtu_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_RECV  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_RCRC  = 4'b0100,
    ST_SEND  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    rx_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_RECV: begin
        rx_ready    = 1'b1;
        cmd.rx_take = rx_valid;
        if (rx_valid && rx_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.do_read) begin
          state_next = ST_RCRC;
        end else if (stat.do_echo) begin
          state_next = ST_SEND;
        end else begin
          state_next = ST_RECV;
        end
      end
      ST_RCRC: begin
        cmd.rcrc_step = 1'b1;
        if (stat.rcrc_last) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          if (stat.send_last) begin
            state_next = ST_RECV;
          end
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

endmodule

>>> rtl/mrtu_dp.sv
module mrtu_dp (
  input  logic            clk,
  input  logic            rst,
  input  mrtu_pkg::cmd_t  cmd,
  output mrtu_pkg::stat_t stat,
  input  mrtu_pkg::cfg_t  cfg,
  input  logic [7:0]      rx_byte,
  input  logic            rx_last,
  input  logic [15:0]     valve_state,
  input  logic [15:0]     battery_mv,
  input  logic [15:0]     panel_mv,
  input  logic [15:0]     current_ma,
  input  logic [15:0]     encoder_low,
  input  logic            tx_ready,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            tx_last,
  output logic [1:0]      valve_action
);

  logic [7:0]  frame_store [mrtu_pkg::FRAME_BYTES];
  logic [3:0]  byte_count;
  logic [15:0] running_crc;
  logic [15:0] read_value;
  logic [1:0]  action;
  logic        is_echo;
  logic [15:0] resp_crc;
  logic [2:0]  idx;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [1:0]  out_action;

  logic [7:0]  fn;
  logic [15:0] addr;
  logic [15:0] data;
  logic [15:0] rx_crc;
  logic        frame_ok;
  logic [15:0] value_sel;
  logic [7:0]  read_byte;
  logic [7:0]  send_byte;
  logic        send_last;

  // Request decode from the stored frame
  assign fn       = frame_store[1];
  assign addr     = {frame_store[2], frame_store[3]};
  assign data     = {frame_store[4], frame_store[5]};
  assign rx_crc   = {frame_store[7], frame_store[6]};
  assign frame_ok = (byte_count >= 4'(mrtu_pkg::FRAME_BYTES)) && (rx_crc == running_crc) &&
                    (frame_store[0] == cfg.device_address);

  // Register lookup; address bytes are already stored when the frame is full
  always_comb begin
    if (addr == cfg.valve_state_address) begin
      value_sel = valve_state;
    end else if (addr == cfg.battery_voltage_address) begin
      value_sel = battery_mv;
    end else if (addr == cfg.panel_voltage_address) begin
      value_sel = panel_mv;
    end else if (addr == cfg.current_address) begin
      value_sel = current_ma;
    end else if (addr == cfg.encoder_address) begin
      value_sel = encoder_low;
    end else begin
      value_sel = mrtu_pkg::UNKNOWN_VALUE;
    end
  end

  // Read response bytes
  always_comb begin
    case (idx)
      3'd0:    read_byte = cfg.device_address;
      3'd1:    read_byte = mrtu_pkg::FN_READ;
      3'd2:    read_byte = mrtu_pkg::READ_BYTE_COUNT;
      3'd3:    read_byte = read_value[15:8];
      3'd4:    read_byte = read_value[7:0];
      3'd5:    read_byte = resp_crc[7:0];
      3'd6:    read_byte = resp_crc[15:8];
      default: read_byte = 8'h00;
    endcase
  end

  assign send_byte = is_echo ? frame_store[idx] : read_byte;
  assign send_last = is_echo ? (idx == 3'(mrtu_pkg::FRAME_BYTES - 1))
                             : (idx == 3'(mrtu_pkg::READ_RESP_BYTES - 1));

  // Status to the controller
  assign stat.do_read   = frame_ok && (fn == mrtu_pkg::FN_READ);
  assign stat.do_echo   = frame_ok && (fn == mrtu_pkg::FN_WRITE) &&
                          (addr == cfg.valve_command_address);
  assign stat.rcrc_last = (idx == 3'(mrtu_pkg::READ_CRC_BYTES - 1));
  assign stat.send_last = send_last;
  assign stat.out_free  = !out_valid || tx_ready;

  // Control state: count, running CRC, byte index, output valid, echo flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= mrtu_pkg::CRC_INIT;
      idx         <= '0;
      out_valid   <= 1'b0;
      is_echo     <= 1'b0;
    end else begin
      if (cmd.rx_take && (byte_count < 4'(mrtu_pkg::FRAME_BYTES))) begin
        if (byte_count < 4'(mrtu_pkg::CRC_BYTES)) begin
          running_crc <= mrtu_pkg::crc_update(running_crc, rx_byte);
        end
        byte_count <= byte_count + 4'd1;
      end
      if (cmd.check) begin
        byte_count  <= '0;
        running_crc <= mrtu_pkg::CRC_INIT;
        idx         <= '0;
        is_echo     <= stat.do_echo;
      end
      if (cmd.rcrc_step) begin
        idx <= stat.rcrc_last ? 3'd0 : idx + 3'd1;
      end
      if (cmd.push) begin
        idx       <= idx + 3'd1;
        out_valid <= 1'b1;
      end else if (tx_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame store and payload registers
  always_ff @(posedge clk) begin
    if (cmd.rx_take && (byte_count < 4'(mrtu_pkg::FRAME_BYTES))) begin
      frame_store[byte_count[2:0]] <= rx_byte;
    end
    if (cmd.rx_take && rx_last) begin
      read_value <= value_sel;
    end
    if (cmd.check) begin
      resp_crc <= mrtu_pkg::CRC_INIT;
      action   <= (data == mrtu_pkg::OPEN_VALUE) ? mrtu_pkg::ACT_OPEN : mrtu_pkg::ACT_CLOSE;
    end
    if (cmd.rcrc_step) begin
      resp_crc <= mrtu_pkg::crc_update(resp_crc, read_byte);
    end
    if (cmd.push) begin
      out_byte   <= send_byte;
      out_last   <= send_last;
      out_action <= (is_echo && (idx == 3'd0)) ? action : mrtu_pkg::ACT_NONE;
    end
  end

  assign tx_valid     = out_valid;
  assign tx_byte      = out_byte;
  assign tx_last      = out_last;
  assign valve_action = out_action;

endmodule

>>> rtl/mrtu_checker.sv
`include "modbus_rtu_slave_frame_handler_assert.svh"

module mrtu_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       rx_last,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_byte,
  input logic       tx_last,
  input logic [1:0] valve_action
);

  // A stalled response byte holds its payload
  `MRTU_ASSERT_NXT(a_tx_hold, clk, rst, tx_valid && !tx_ready, tx_valid && $stable(tx_byte) && $stable(tx_last) && $stable(valve_action))

  // Frame end: the next cycle is spent checking, no byte taken
  `MRTU_ASSERT_NXT(a_rx_pause, clk, rst, rx_valid && rx_ready && rx_last, !rx_ready)

  // A valve action only rides on the first echo byte, never the last
  `MRTU_ASSERT_IMP(a_act_first, clk, rst, tx_valid && (valve_action != mrtu_pkg::ACT_NONE), !tx_last)

  // Nothing is offered right after reset
  `MRTU_ASSERT_RST(a_rst_quiet, clk, rst, !tx_valid)

endmodule

bind modbus_rtu_slave_frame_handler mrtu_checker u_mrtu_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .rx_last      (rx.rx_last),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .tx_byte      (tx.tx_byte),
  .tx_last      (tx.tx_last),
  .valve_action (tx.valve_action)
);
